/* rtl/polyhedron_bond_angles_defines.svh */
// Assertion macros shared by the polyhedron bond-angle RTL.
`ifndef POLYHEDRON_BOND_ANGLES_DEFINES_SVH
`define POLYHEDRON_BOND_ANGLES_DEFINES_SVH

// Same-cycle implication, checked on clk and idle during reset.
`define PBA_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on clk and idle during reset.
`define PBA_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/pba_pkg.sv */
// Types, constants and tables shared by the polyhedron bond-angle block.
package pba_pkg;

  typedef logic signed [23:0] coord_t;
  typedef logic [22:0]        cell_t;

  typedef struct packed {
    coord_t x;
    coord_t y;
    coord_t z;
  } pos_t;

  typedef struct packed {
    logic   op;
    coord_t pos_x;
    coord_t pos_y;
    coord_t pos_z;
  } in_word_t;

  typedef struct packed {
    logic [15:0] angle_deg;
    logic        is_marker;
    logic        degenerate;
    logic        overflow;
    logic        last;
  } out_word_t;

  typedef struct packed {
    logic [1:0] index;
    cell_t      wdata;
  } cfg_word_t;

  localparam logic [1:0] REG_CELL_X = 2'd0;
  localparam logic [1:0] REG_CELL_Y = 2'd1;
  localparam logic [1:0] REG_CELL_Z = 2'd2;

  // Ligand counts and slots; wide enough for a neighbor capacity of up to 15.
  localparam int LIG_CNT_W = 4;
  typedef logic [LIG_CNT_W-1:0] lig_cnt_t;

  typedef enum logic [1:0] {
    CMD_CENTER = 2'd0,
    CMD_LIGAND = 2'd1,
    CMD_END    = 2'd2
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t kind;
    lig_cnt_t  slot;
    logic      dropped;
    pos_t      pos;
  } cmd_t;

  typedef struct packed {
    logic start;
    pos_t lig_a;
    pos_t lig_b;
    pos_t center;
  } ang_req_t;

  typedef struct packed {
    logic        done;
    logic [15:0] angle;
    logic        degen;
  } ang_rsp_t;

  localparam logic [4:0] DIST_STEPS = 5'd9;
  localparam logic [4:0] SQRT_LAST  = 5'd30;
  localparam logic [4:0] DIV_LAST   = 5'd16;
  localparam logic [4:0] ROT_LAST   = 5'd15;

  localparam logic signed [25:0] Z_QUARTER = 26'sd5898240;
  localparam logic [17:0]        ANGLE_MAX = 18'd46080;

  // CORDIC arctangent steps, Q.16 degrees.
  function automatic logic [21:0] atan_q16(input logic [3:0] i);
    logic [21:0] v;
    case (i)
      4'd0:    v = 22'd2949120;
      4'd1:    v = 22'd1740967;
      4'd2:    v = 22'd919879;
      4'd3:    v = 22'd466945;
      4'd4:    v = 22'd234379;
      4'd5:    v = 22'd117304;
      4'd6:    v = 22'd58666;
      4'd7:    v = 22'd29335;
      4'd8:    v = 22'd14668;
      4'd9:    v = 22'd7334;
      4'd10:   v = 22'd3667;
      4'd11:   v = 22'd1833;
      4'd12:   v = 22'd917;
      4'd13:   v = 22'd458;
      4'd14:   v = 22'd229;
      4'd15:   v = 22'd115;
      default: v = 22'd0;
    endcase
    return v;
  endfunction

endpackage

/* rtl/pba_chan_if.sv */
// Valid/ready channel carrying one payload word.
interface pba_chan_if #(parameter type payload_t = logic);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

/* rtl/pba_front.sv */
// Front end: accepts atom and separator words and turns them into commands.
module pba_front #(
  parameter int MAX_NEIGHBORS
) (
  input  logic          clk,
  input  logic          rst_n,
  pba_chan_if.sink      in_ch,
  output pba_pkg::cmd_t push_cmd,
  output logic          push_valid,
  input  logic          push_ready
);
  import pba_pkg::*;

  localparam int CNT_W = $clog2(MAX_NEIGHBORS + 1);

  logic             expect_r, expect_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             dropped_r, dropped_nxt;

  assign in_ch.ready = push_ready;

  always_comb begin
    expect_nxt    = expect_r;
    cnt_nxt       = cnt_r;
    dropped_nxt   = dropped_r;
    push_valid    = 1'b0;
    push_cmd.kind    = CMD_CENTER;
    push_cmd.slot    = lig_cnt_t'(cnt_r);
    push_cmd.dropped = dropped_r;
    push_cmd.pos     = '{x: in_ch.data.pos_x, y: in_ch.data.pos_y, z: in_ch.data.pos_z};
    if (in_ch.valid && push_ready) begin
      if (!in_ch.data.op) begin
        if (expect_r) begin
          push_valid = 1'b1;
          expect_nxt = 1'b0;
        end else if (cnt_r < CNT_W'(MAX_NEIGHBORS)) begin
          push_valid    = 1'b1;
          push_cmd.kind = CMD_LIGAND;
          cnt_nxt       = cnt_r + CNT_W'(1);
        end else begin
          // capacity reached: drop the ligand, remember it for the marker
          dropped_nxt = 1'b1;
        end
      end else begin
        push_valid    = 1'b1;
        push_cmd.kind = CMD_END;
        expect_nxt    = 1'b1;
        cnt_nxt       = '0;
        dropped_nxt   = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      expect_r  <= 1'b1;
      cnt_r     <= '0;
      dropped_r <= 1'b0;
    end else begin
      expect_r  <= expect_nxt;
      cnt_r     <= cnt_nxt;
      dropped_r <= dropped_nxt;
    end
  end

endmodule

/* rtl/pba_fifo.sv */
// Short command queue between the front end and the back end.
module pba_fifo #(
  parameter int DEPTH
) (
  input  logic          clk,
  input  logic          rst_n,
  input  pba_pkg::cmd_t wr_data,
  input  logic          wr_valid,
  output logic          wr_ready,
  output pba_pkg::cmd_t rd_data,
  output logic          rd_valid,
  input  logic          rd_ready
);
  import pba_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  cmd_t             slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             do_wr, do_rd;

  assign wr_ready = (cnt_r != CNT_W'(DEPTH));
  assign rd_valid = (cnt_r != '0);
  assign rd_data  = slots[rd_ptr_r];
  assign do_wr    = wr_valid && wr_ready;
  assign do_rd    = rd_valid && rd_ready;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_wr) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (do_rd) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (do_wr && !do_rd) begin
      cnt_nxt = cnt_r + CNT_W'(1);
    end else if (do_rd && !do_wr) begin
      cnt_nxt = cnt_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      slots[wr_ptr_r] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

endmodule

/* rtl/pba_angle.sv */
// Multi-cycle angle unit: distances, square roots, cosine divide and CORDIC.
module pba_angle (
  input  logic              clk,
  input  logic              rst_n,
  input  pba_pkg::cell_t    cell_x,
  input  pba_pkg::cell_t    cell_y,
  input  pba_pkg::cell_t    cell_z,
  input  pba_pkg::ang_req_t req,
  output pba_pkg::ang_rsp_t rsp
);
  import pba_pkg::*;

  typedef enum logic [12:0] {
    A_IDLE = 13'b0000000000001,
    A_DIST = 13'b0000000000010,
    A_ZCHK = 13'b0000000000100,
    A_SQ1  = 13'b0000000001000,
    A_SQ2  = 13'b0000000010000,
    A_MUL  = 13'b0000000100000,
    A_CMP  = 13'b0000001000000,
    A_NORM = 13'b0000010000000,
    A_DIV  = 13'b0000100000000,
    A_QSQ  = 13'b0001000000000,
    A_SQS  = 13'b0010000000000,
    A_ROT  = 13'b0100000000000,
    A_DONE = 13'b1000000000000
  } astate_t;

  astate_t state_r, state_nxt;
  logic [4:0] step_r, step_nxt;
  logic [1:0] dsel_r, dsel_nxt;
  logic [1:0] axis_r, axis_nxt;
  logic       s1_v_r, s1_v_nxt;
  logic [1:0] s1_tag_r, s1_tag_nxt;
  logic [24:0] mm_r, mm_nxt;
  logic [50:0] d1_r, d1_nxt, d2_r, d2_nxt, dij_r, dij_nxt;
  logic [61:0] sq_rad_r, sq_rad_nxt;
  logic [33:0] sq_rem_r, sq_rem_nxt;
  logic [30:0] sq_root_r, sq_root_nxt;
  logic [30:0] r1_r, r1_nxt;
  logic [62:0] den_r, den_nxt;
  logic [60:0] mag_r, mag_nxt;
  logic        neg_r, neg_nxt;
  logic [47:0] rem_r, rem_nxt;
  logic [16:0] q_r, q_nxt;
  logic signed [19:0] x_r, x_nxt, y_r, y_nxt;
  logic signed [25:0] z_r, z_nxt;
  logic        degen_r, degen_nxt;

  // distance stage 1 signals
  pos_t        pp, qp;
  coord_t      pc, qc;
  cell_t       cl;
  logic signed [24:0] dd;
  logic signed [25:0] dw, dm, dp;
  logic [25:0] ad, am, ap, amin;
  logic [49:0] sq;

  // square root step
  logic [33:0] rem_sh, trial, sq_rem_step;
  logic [30:0] sq_root_step;

  // cosine and CORDIC helpers
  logic signed [52:0] nsum;
  logic [52:0] absn;
  logic [47:0] tdiv;
  logic [33:0] qq;
  logic [32:0] srad;
  logic        cneg;
  logic signed [19:0] xs, ys;
  logic signed [25:0] at;
  logic signed [26:0] zr;
  logic [17:0] rr;

  function automatic logic [25:0] abs26(input logic signed [25:0] v);
    return v[25] ? 26'(-v) : 26'(v);
  endfunction

  always_comb begin
    case (dsel_r)
      2'd0:    begin pp = req.lig_a; qp = req.center; end
      2'd1:    begin pp = req.lig_b; qp = req.center; end
      default: begin pp = req.lig_a; qp = req.lig_b;  end
    endcase
    case (axis_r)
      2'd0:    begin pc = pp.x; qc = qp.x; cl = cell_x; end
      2'd1:    begin pc = pp.y; qc = qp.y; cl = cell_y; end
      default: begin pc = pp.z; qc = qp.z; cl = cell_z; end
    endcase
    dd   = 25'(pc) - 25'(qc);
    dw   = 26'(dd);
    dm   = dw - $signed({3'b000, cl});
    dp   = dw + $signed({3'b000, cl});
    ad   = abs26(dw);
    am   = abs26(dm);
    ap   = abs26(dp);
    amin = ad;
    if (am < amin) amin = am;
    if (ap < amin) amin = ap;
  end

  assign sq = mm_r * mm_r;

  always_comb begin
    rem_sh = {sq_rem_r[31:0], sq_rad_r[61:60]};
    trial  = {1'b0, sq_root_r, 2'b01};
    if (rem_sh >= trial) begin
      sq_rem_step  = rem_sh - trial;
      sq_root_step = {sq_root_r[29:0], 1'b1};
    end else begin
      sq_rem_step  = rem_sh;
      sq_root_step = {sq_root_r[29:0], 1'b0};
    end
  end

  assign nsum = $signed({2'b00, d1_r}) + $signed({2'b00, d2_r}) - $signed({2'b00, dij_r});
  assign absn = nsum[52] ? 53'(-nsum) : 53'(nsum);
  assign tdiv = (step_r == '0) ? rem_r : {rem_r[46:0], 1'b0};
  assign qq   = q_r * q_r;
  assign srad = 33'h1_0000_0000 - qq[32:0];
  assign cneg = neg_r && (q_r != '0);
  assign xs   = x_r >>> step_r[3:0];
  assign ys   = y_r >>> step_r[3:0];
  assign at   = $signed({4'b0000, atan_q16(step_r[3:0])});
  assign zr   = 27'(z_r) + 27'sd128;

  always_comb begin
    if (z_r[25]) begin
      rr = '0;
    end else begin
      rr = zr[25:8];
      if (rr > ANGLE_MAX) rr = ANGLE_MAX;
    end
  end

  assign rsp.done  = (state_r == A_DONE);
  assign rsp.angle = rr[15:0];
  assign rsp.degen = degen_r;

  always_comb begin
    state_nxt   = state_r;
    step_nxt    = step_r;
    dsel_nxt    = dsel_r;
    axis_nxt    = axis_r;
    s1_v_nxt    = 1'b0;
    s1_tag_nxt  = s1_tag_r;
    mm_nxt      = mm_r;
    d1_nxt      = d1_r;
    d2_nxt      = d2_r;
    dij_nxt     = dij_r;
    sq_rad_nxt  = sq_rad_r;
    sq_rem_nxt  = sq_rem_r;
    sq_root_nxt = sq_root_r;
    r1_nxt      = r1_r;
    den_nxt     = den_r;
    mag_nxt     = mag_r;
    neg_nxt     = neg_r;
    rem_nxt     = rem_r;
    q_nxt       = q_r;
    x_nxt       = x_r;
    y_nxt       = y_r;
    z_nxt       = z_r;
    degen_nxt   = degen_r;

    case (state_r)
      A_IDLE: begin
        if (req.start) begin
          step_nxt  = '0;
          dsel_nxt  = '0;
          axis_nxt  = '0;
          d1_nxt    = '0;
          d2_nxt    = '0;
          dij_nxt   = '0;
          degen_nxt = 1'b0;
          state_nxt = A_DIST;
        end
      end
      A_DIST: begin
        // stage 1: nearest image magnitude for one axis of one distance
        if (step_r < DIST_STEPS) begin
          s1_v_nxt   = 1'b1;
          s1_tag_nxt = dsel_r;
          mm_nxt     = amin[24:0];
          if (axis_r == 2'd2) begin
            axis_nxt = '0;
            dsel_nxt = dsel_r + 2'd1;
          end else begin
            axis_nxt = axis_r + 2'd1;
          end
          step_nxt = step_r + 5'd1;
        end else begin
          state_nxt = A_ZCHK;
        end
        // stage 2: square and accumulate
        if (s1_v_r) begin
          case (s1_tag_r)
            2'd0:    d1_nxt  = d1_r  + {1'b0, sq};
            2'd1:    d2_nxt  = d2_r  + {1'b0, sq};
            default: dij_nxt = dij_r + {1'b0, sq};
          endcase
        end
      end
      A_ZCHK: begin
        if ((d1_r == '0) || (d2_r == '0)) begin
          degen_nxt = 1'b1;
          z_nxt     = '0;
          state_nxt = A_DONE;
        end else begin
          sq_rad_nxt  = {1'b0, d1_r, 10'b0};
          sq_rem_nxt  = '0;
          sq_root_nxt = '0;
          step_nxt    = '0;
          state_nxt   = A_SQ1;
        end
      end
      A_SQ1: begin
        sq_rad_nxt  = {sq_rad_r[59:0], 2'b00};
        sq_rem_nxt  = sq_rem_step;
        sq_root_nxt = sq_root_step;
        step_nxt    = step_r + 5'd1;
        if (step_r == SQRT_LAST) begin
          r1_nxt      = sq_root_step;
          sq_rad_nxt  = {1'b0, d2_r, 10'b0};
          sq_rem_nxt  = '0;
          sq_root_nxt = '0;
          step_nxt    = '0;
          state_nxt   = A_SQ2;
        end
      end
      A_SQ2: begin
        sq_rad_nxt  = {sq_rad_r[59:0], 2'b00};
        sq_rem_nxt  = sq_rem_step;
        sq_root_nxt = sq_root_step;
        step_nxt    = step_r + 5'd1;
        if (step_r == SQRT_LAST) begin
          state_nxt = A_MUL;
        end
      end
      A_MUL: begin
        den_nxt   = {62'(r1_r) * 62'(sq_root_r), 1'b0};
        neg_nxt   = nsum[52];
        mag_nxt   = {absn[50:0], 10'b0};
        state_nxt = A_CMP;
      end
      A_CMP: begin
        if ({2'b00, mag_r} >= den_r) begin
          q_nxt     = 17'h10000;
          state_nxt = A_QSQ;
        end else begin
          state_nxt = A_NORM;
        end
      end
      A_NORM: begin
        if (den_r[62:47] != '0) begin
          den_nxt = {1'b0, den_r[62:1]};
          mag_nxt = {1'b0, mag_r[60:1]};
        end else begin
          rem_nxt   = mag_r[47:0];
          q_nxt     = '0;
          step_nxt  = '0;
          state_nxt = A_DIV;
        end
      end
      A_DIV: begin
        if (tdiv >= den_r[47:0]) begin
          rem_nxt = tdiv - den_r[47:0];
          q_nxt   = {q_r[15:0], 1'b1};
        end else begin
          rem_nxt = tdiv;
          q_nxt   = {q_r[15:0], 1'b0};
        end
        step_nxt = step_r + 5'd1;
        if (step_r == DIV_LAST) begin
          state_nxt = A_QSQ;
        end
      end
      A_QSQ: begin
        sq_rad_nxt  = {29'b0, srad};
        sq_rem_nxt  = '0;
        sq_root_nxt = '0;
        step_nxt    = '0;
        state_nxt   = A_SQS;
      end
      A_SQS: begin
        sq_rad_nxt  = {sq_rad_r[59:0], 2'b00};
        sq_rem_nxt  = sq_rem_step;
        sq_root_nxt = sq_root_step;
        step_nxt    = step_r + 5'd1;
        if (step_r == SQRT_LAST) begin
          // negative cosine: start a quarter turn on
          if (cneg) begin
            x_nxt = $signed({3'b000, sq_root_step[16:0]});
            y_nxt = $signed({3'b000, q_r});
            z_nxt = Z_QUARTER;
          end else begin
            x_nxt = $signed({3'b000, q_r});
            y_nxt = $signed({3'b000, sq_root_step[16:0]});
            z_nxt = '0;
          end
          step_nxt  = '0;
          state_nxt = A_ROT;
        end
      end
      A_ROT: begin
        if (!y_r[19]) begin
          x_nxt = x_r + ys;
          y_nxt = y_r - xs;
          z_nxt = z_r + at;
        end else begin
          x_nxt = x_r - ys;
          y_nxt = y_r + xs;
          z_nxt = z_r - at;
        end
        step_nxt = step_r + 5'd1;
        if (step_r == ROT_LAST) begin
          state_nxt = A_DONE;
        end
      end
      A_DONE: begin
        state_nxt = A_IDLE;
      end
      default: begin
        state_nxt = A_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= A_IDLE;
      s1_v_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      s1_v_r  <= s1_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    step_r    <= step_nxt;
    dsel_r    <= dsel_nxt;
    axis_r    <= axis_nxt;
    s1_tag_r  <= s1_tag_nxt;
    mm_r      <= mm_nxt;
    d1_r      <= d1_nxt;
    d2_r      <= d2_nxt;
    dij_r     <= dij_nxt;
    sq_rad_r  <= sq_rad_nxt;
    sq_rem_r  <= sq_rem_nxt;
    sq_root_r <= sq_root_nxt;
    r1_r      <= r1_nxt;
    den_r     <= den_nxt;
    mag_r     <= mag_nxt;
    neg_r     <= neg_nxt;
    rem_r     <= rem_nxt;
    q_r       <= q_nxt;
    x_r       <= x_nxt;
    y_r       <= y_nxt;
    z_r       <= z_nxt;
    degen_r   <= degen_nxt;
  end

endmodule

/* rtl/pba_back.sv */
// Back end: holds center and ligands, walks ligand pairs, drives the result word.
module pba_back #(
  parameter int MAX_NEIGHBORS
) (
  input  logic              clk,
  input  logic              rst_n,
  input  pba_pkg::cmd_t     cmd,
  input  logic              cmd_valid,
  output logic              cmd_ready,
  output pba_pkg::ang_req_t req,
  input  pba_pkg::ang_rsp_t rsp,
  pba_chan_if.source        out_ch
);
  import pba_pkg::*;

  localparam int IDX_W = $clog2(MAX_NEIGHBORS);

  typedef enum logic [5:0] {
    B_IDLE  = 6'b000001,
    B_READ  = 6'b000010,
    B_START = 6'b000100,
    B_WAIT  = 6'b001000,
    B_EMIT  = 6'b010000,
    B_MARK  = 6'b100000
  } bstate_t;

  bstate_t   state_r, state_nxt;
  pos_t      lig_mem [MAX_NEIGHBORS];
  pos_t      lig_a_r, lig_b_r;
  pos_t      center_r, center_nxt;
  lig_cnt_t  cnt_r, cnt_nxt;
  lig_cnt_t  i_r, i_nxt, j_r, j_nxt;
  logic      drop_r, drop_nxt;
  ang_rsp_t  res_r, res_nxt;
  logic      out_valid_r, out_valid_nxt;
  out_word_t out_data_r, out_data_nxt;
  logic      out_free;

  assign out_free     = !out_valid_r || out_ch.ready;
  assign out_ch.valid = out_valid_r;
  assign out_ch.data  = out_data_r;

  assign req.lig_a  = lig_a_r;
  assign req.lig_b  = lig_b_r;
  assign req.center = center_r;
  assign req.start  = (state_r == B_START);

  always_ff @(posedge clk) begin
    if ((state_r == B_IDLE) && cmd_valid && (cmd.kind == CMD_LIGAND)) begin
      lig_mem[cmd.slot[IDX_W-1:0]] <= cmd.pos;
    end
    if (state_r == B_READ) begin
      lig_a_r <= lig_mem[i_r[IDX_W-1:0]];
      lig_b_r <= lig_mem[j_r[IDX_W-1:0]];
    end
  end

  always_comb begin
    state_nxt     = state_r;
    center_nxt    = center_r;
    cnt_nxt       = cnt_r;
    i_nxt         = i_r;
    j_nxt         = j_r;
    drop_nxt      = drop_r;
    res_nxt       = res_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    out_data_nxt  = out_data_r;
    cmd_ready     = 1'b0;

    case (state_r)
      B_IDLE: begin
        cmd_ready = 1'b1;
        if (cmd_valid) begin
          case (cmd.kind)
            CMD_CENTER: center_nxt = cmd.pos;
            CMD_END: begin
              cnt_nxt   = cmd.slot;
              drop_nxt  = cmd.dropped;
              i_nxt     = '0;
              j_nxt     = lig_cnt_t'(1);
              state_nxt = (cmd.slot >= lig_cnt_t'(2)) ? B_READ : B_MARK;
            end
            default: ;
          endcase
        end
      end
      B_READ:  state_nxt = B_START;
      B_START: state_nxt = B_WAIT;
      B_WAIT: begin
        if (rsp.done) begin
          res_nxt   = rsp;
          state_nxt = B_EMIT;
        end
      end
      B_EMIT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = '{angle_deg: res_r.angle, is_marker: 1'b0,
                            degenerate: res_r.degen, overflow: 1'b0, last: 1'b0};
          if (j_r + lig_cnt_t'(1) < cnt_r) begin
            j_nxt     = j_r + lig_cnt_t'(1);
            state_nxt = B_READ;
          end else if (i_r + lig_cnt_t'(2) < cnt_r) begin
            i_nxt     = i_r + lig_cnt_t'(1);
            j_nxt     = i_r + lig_cnt_t'(2);
            state_nxt = B_READ;
          end else begin
            state_nxt = B_MARK;
          end
        end
      end
      B_MARK: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = '{angle_deg: 16'd0, is_marker: 1'b1,
                            degenerate: 1'b0, overflow: drop_r, last: 1'b1};
          state_nxt     = B_IDLE;
        end
      end
      default: state_nxt = B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_IDLE;
      center_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      center_r    <= center_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cnt_r      <= cnt_nxt;
    i_r        <= i_nxt;
    j_r        <= j_nxt;
    drop_r     <= drop_nxt;
    res_r      <= res_nxt;
    out_data_r <= out_data_nxt;
  end

endmodule

/* rtl/polyhedron_bond_angles.sv */
// Top level of the polyhedron bond-angle block: config registers and wiring.
//
// Channels: in_ch takes one word per atom (op 0, signed Q8.16 position) or
// a separator (op 1). The first atom after a separator is the center, the
// next MAX_NEIGHBORS atoms are ligands; later ligands are dropped and the
// drop is reported on the marker. out_ch gives, on each separator, one word
// per ligand pair i<j (angle in Q8.8 degrees) and then a marker word with
// last set. cfg_ch writes the three cell lengths; it is always ready and
// must only be used while the block is idle.
// Flow: atom words are absorbed by a QUEUE_DEPTH-word command queue. Each
// pair passes at most distance sums, two 31-step square roots, normalize
// shifts, a 17-step divide, a 31-step sine root and 16 CORDIC steps in the
// angle unit, then the back end's sequencing; the marker comes last. The
// shared angle unit sets the rate: it works on one pair at a time, and a
// separator with n ligands yields n*(n-1)/2 pair words.
// Reset (rst_n low, synchronous) empties the queue, clears the cell lengths
// and returns both ends to waiting for a center. When out_ch stalls, the
// back end holds its word and stops; the front keeps accepting until the
// queue fills, then drops in_ch.ready.
`include "polyhedron_bond_angles_defines.svh"

module polyhedron_bond_angles #(
  parameter int MAX_NEIGHBORS = 8,
  parameter int QUEUE_DEPTH   = 4
) (
  input  logic       clk,
  input  logic       rst_n,
  pba_chan_if.sink   in_ch,
  pba_chan_if.source out_ch,
  pba_chan_if.sink   cfg_ch
);
  import pba_pkg::*;

  cell_t    cell_x_r, cell_y_r, cell_z_r;
  cmd_t     push_cmd, pop_cmd;
  logic     push_valid, push_ready;
  logic     pop_valid, pop_ready;
  ang_req_t ang_req;
  ang_rsp_t ang_rsp;

  // cell length registers; an unknown index writes nothing
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cell_x_r <= '0;
      cell_y_r <= '0;
      cell_z_r <= '0;
    end else if (cfg_ch.valid) begin
      case (cfg_ch.data.index)
        REG_CELL_X: cell_x_r <= cfg_ch.data.wdata;
        REG_CELL_Y: cell_y_r <= cfg_ch.data.wdata;
        REG_CELL_Z: cell_z_r <= cfg_ch.data.wdata;
        default: ;
      endcase
    end
  end

  // classify incoming words
  pba_front #(.MAX_NEIGHBORS(MAX_NEIGHBORS)) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .push_cmd   (push_cmd),
    .push_valid (push_valid),
    .push_ready (push_ready)
  );

  // decouple front and back
  pba_fifo #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_data  (push_cmd),
    .wr_valid (push_valid),
    .wr_ready (push_ready),
    .rd_data  (pop_cmd),
    .rd_valid (pop_valid),
    .rd_ready (pop_ready)
  );

  // store ligands, walk the pairs, drive results
  pba_back #(.MAX_NEIGHBORS(MAX_NEIGHBORS)) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (pop_cmd),
    .cmd_valid (pop_valid),
    .cmd_ready (pop_ready),
    .req       (ang_req),
    .rsp       (ang_rsp),
    .out_ch    (out_ch)
  );

  // one pair angle at a time
  pba_angle u_angle (
    .clk    (clk),
    .rst_n  (rst_n),
    .cell_x (cell_x_r),
    .cell_y (cell_y_r),
    .cell_z (cell_z_r),
    .req    (ang_req),
    .rsp    (ang_rsp)
  );

  `PBA_ASSERT_IMP(a_degen_zero, out_ch.valid && out_ch.data.degenerate, out_ch.data.angle_deg == 16'd0 && !out_ch.data.is_marker, "degenerate pair word carries a nonzero angle")
  `PBA_ASSERT_IMP(a_marker_last, out_ch.valid, out_ch.data.is_marker == out_ch.data.last, "marker and last flags disagree")
  `PBA_ASSERT_IMP(a_pair_no_ovf, out_ch.valid && !out_ch.data.is_marker, !out_ch.data.overflow && out_ch.data.angle_deg <= 16'd46080, "pair word flags overflow or exceeds 180 degrees")
  `PBA_ASSERT_NXT(a_cfg_x, cfg_ch.valid && cfg_ch.ready && cfg_ch.data.index == REG_CELL_X, cell_x_r == $past(cfg_ch.data.wdata), "cell x register missed its write")

endmodule

/* dv/testbench.sv */
// Self-checking testbench for the polyhedron bond-angle block.
module testbench;
  import pba_pkg::*;

  localparam int          NEIGHBOR_CAP  = 8;
  localparam int          RANDOM_WORDS  = 300;
  localparam int          WATCHDOG_MAX  = 20000;
  localparam int          SETTLE_CYCLES = 64;
  localparam logic [1:0]  REG_UNUSED    = 2'd3;
  localparam logic        OP_ATOM       = 1'b0;
  localparam logic        OP_END        = 1'b1;

  // Expected angle words for one polyhedron stream, plus the block's own state.
  class angle_scoreboard;
    out_word_t   pending[$];
    int          errors;
    int          checked;
    int          degen_seen;
    int          overflow_seen;
    cell_t       cell_len[3];
    pos_t        center;
    pos_t        ligands[NEIGHBOR_CAP];
    int          n_lig;
    bit          want_center;
    bit          dropped;

    function new();
      cell_len[0] = '0;
      cell_len[1] = '0;
      cell_len[2] = '0;
      center = '0;
      n_lig = 0;
      want_center = 1'b1;
      dropped = 1'b0;
    endfunction

    function void set_cell(logic [1:0] idx, cell_t v);
      if (idx <= REG_CELL_Z) cell_len[idx] = v;
    endfunction

    function longint unsigned square_mag(longint v);
      longint unsigned m;
      m = (v < 0) ? longint'(-v) : v;
      return m * m;
    endfunction

    // Nearest periodic image along one axis.
    function longint unsigned axis_sq(longint d, longint c);
      longint unsigned a, b, e;
      a = square_mag(d);
      b = square_mag(d - c);
      e = square_mag(d + c);
      if (a > b) a = b;
      if (a > e) a = e;
      return a;
    endfunction

    function longint unsigned sep_sq(pos_t p, pos_t q);
      return axis_sq(longint'(p.x) - longint'(q.x), longint'(cell_len[0]))
           + axis_sq(longint'(p.y) - longint'(q.y), longint'(cell_len[1]))
           + axis_sq(longint'(p.z) - longint'(q.z), longint'(cell_len[2]));
    endfunction

    function longint unsigned int_sqrt(longint unsigned v);
      longint unsigned res, bitv;
      res = 0;
      bitv = 64'd1 << 62;
      while (bitv > v) bitv >>= 2;
      while (bitv != 0) begin
        if (v >= res + bitv) begin
          v -= res + bitv;
          res = (res >> 1) + bitv;
        end else begin
          res >>= 1;
        end
        bitv >>= 2;
      end
      return res;
    endfunction

    // CORDIC arc cosine, Q.16 cosine in, Q8.8 degrees out.
    function logic [15:0] arc_cos_deg(longint c);
      longint        q, x, y, z, xs, ys;
      longint        tab[16];
      longint unsigned r;
      tab = '{2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
              14668, 7334, 3667, 1833, 917, 458, 229, 115};
      q = (c < 0) ? -c : c;
      x = c;
      y = longint'(int_sqrt((64'd1 << 32) - longint'(q * q)));
      z = 0;
      if (x < 0) begin
        xs = x;
        x = y;
        y = -xs;
        z = 90 * 65536;
      end
      for (int i = 0; i < 16; i++) begin
        xs = x >>> i;
        ys = y >>> i;
        if (y >= 0) begin
          x += ys; y -= xs; z += tab[i];
        end else begin
          x -= ys; y += xs; z -= tab[i];
        end
      end
      if (z < 0) return 16'd0;
      r = longint'(z + 128) >> 8;
      return (r > 46080) ? 16'd46080 : r[15:0];
    endfunction

    function out_word_t bond_angle(pos_t a, pos_t b);
      out_word_t       w;
      longint unsigned d1, d2, dab, mag, den, q;
      longint          n;
      w = '0;
      d1 = sep_sq(a, center);
      d2 = sep_sq(b, center);
      dab = sep_sq(a, b);
      if (d1 == 0 || d2 == 0) begin
        w.degenerate = 1'b1;
        return w;
      end
      n = longint'(d1 + d2) - longint'(dab);
      mag = ((n < 0) ? longint'(-n) : n) << 10;
      den = 2 * int_sqrt(d1 << 10) * int_sqrt(d2 << 10);
      if (mag >= den) begin
        q = 65536;
      end else begin
        while (den >= (64'd1 << 47)) begin
          den >>= 1;
          mag >>= 1;
        end
        q = (mag << 16) / den;
      end
      w.angle_deg = arc_cos_deg((n < 0) ? -longint'(q) : longint'(q));
      return w;
    endfunction

    function void note_input(in_word_t w);
      out_word_t m;
      if (w.op == OP_ATOM) begin
        if (want_center) begin
          center = {w.pos_x, w.pos_y, w.pos_z};
          want_center = 1'b0;
        end else if (n_lig < NEIGHBOR_CAP) begin
          ligands[n_lig] = {w.pos_x, w.pos_y, w.pos_z};
          n_lig++;
        end else begin
          dropped = 1'b1;
        end
        return;
      end
      for (int i = 0; i < n_lig; i++)
        for (int j = i + 1; j < n_lig; j++)
          pending.push_back(bond_angle(ligands[i], ligands[j]));
      m = '0;
      m.is_marker = 1'b1;
      m.overflow = dropped;
      m.last = 1'b1;
      pending.push_back(m);
      want_center = 1'b1;
      n_lig = 0;
      dropped = 1'b0;
    endfunction

    function void check(out_word_t got);
      out_word_t exp_w;
      if (pending.size() == 0) begin
        $display("%0t: unexpected word %h", $time, got);
        errors++;
        return;
      end
      exp_w = pending.pop_front();
      checked++;
      if (exp_w.degenerate) degen_seen++;
      if (exp_w.overflow) overflow_seen++;
      if (got.angle_deg != exp_w.angle_deg)
        $display("%0t: angle_deg expected %0d actual %0d", $time,
                 exp_w.angle_deg, got.angle_deg);
      if (got.is_marker != exp_w.is_marker)
        $display("%0t: is_marker expected %0b actual %0b", $time,
                 exp_w.is_marker, got.is_marker);
      if (got.degenerate != exp_w.degenerate)
        $display("%0t: degenerate expected %0b actual %0b", $time,
                 exp_w.degenerate, got.degenerate);
      if (got.overflow != exp_w.overflow)
        $display("%0t: overflow expected %0b actual %0b", $time,
                 exp_w.overflow, got.overflow);
      if (got.last != exp_w.last)
        $display("%0t: last expected %0b actual %0b", $time, exp_w.last, got.last);
      if (got != exp_w) errors++;
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  pba_chan_if #(.payload_t(in_word_t))  in_ch();
  pba_chan_if #(.payload_t(out_word_t)) out_ch();
  pba_chan_if #(.payload_t(cfg_word_t)) cfg_ch();

  polyhedron_bond_angles dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch.sink),
    .out_ch (out_ch.source),
    .cfg_ch (cfg_ch.sink)
  );

  angle_scoreboard sb = new();

  int  idle_cycles = 0;
  int  words_sent = 0;
  int  polys_sent = 0;
  int  burst_left = 0;
  int  stall_mode = 0;
  int  stall_cnt = 0;

  always #10 clk = ~clk;

  initial begin
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    out_ch.ready = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.data = '0;
  end

  // Receiver: stall on a pattern chosen anew whenever the low byte of stall_cnt
  // is all ones: always ready, coin flip, long low stretches, or mostly ready.
  always @(posedge clk) begin
    stall_cnt <= stall_cnt + 1;
    if (stall_cnt[7:0] == 8'hff) stall_mode <= $urandom_range(0, 3);
    case (stall_mode)
      0:       out_ch.ready <= 1'b1;
      1:       out_ch.ready <= 1'($urandom_range(0, 1));
      2:       out_ch.ready <= (stall_cnt[3:0] < 4'd3);
      default: out_ch.ready <= ($urandom_range(0, 7) != 0);
    endcase
  end

  // Check every accepted result word; count idle cycles for the watchdog.
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) sb.check(out_ch.data);
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || !rst_n)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_MAX) begin
      $display("%0t: watchdog expired, %0d words still expected", $time,
               sb.pending.size());
      $display("status: fail");
      $finish;
    end
  end

  // Write one cell register; the port is only used while the block is idle.
  task automatic write_reg(logic [1:0] idx, cell_t v);
    cfg_ch.valid <= 1'b1;
    cfg_ch.data <= '{index: idx, wdata: v};
    do @(posedge clk); while (!cfg_ch.ready);
    sb.set_cell(idx, v);
    cfg_ch.valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic write_cells(cell_t x, cell_t y, cell_t z);
    write_reg(REG_CELL_X, x);
    write_reg(REG_CELL_Y, y);
    write_reg(REG_CELL_Z, z);
  endtask

  // Drive one word, hold it until accepted, then maybe open a gap.
  task automatic send_word(in_word_t w);
    in_ch.valid <= 1'b1;
    in_ch.data <= w;
    do @(posedge clk); while (!in_ch.ready);
    sb.note_input(w);
    words_sent++;
    if (w.op == OP_END) polys_sent++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(0, 15);
      if ($urandom_range(0, 3) != 0) begin
        in_ch.valid <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end
    end
  endtask

  task automatic atom(coord_t x, coord_t y, coord_t z);
    send_word('{op: OP_ATOM, pos_x: x, pos_y: y, pos_z: z});
  endtask

  // Separator carries junk coordinates; the block must ignore them.
  task automatic separator();
    send_word('{op: OP_END, pos_x: coord_t'($urandom), pos_y: coord_t'($urandom),
                pos_z: coord_t'($urandom)});
  endtask

  // Drop valid and hold until every expected word is back, then let the
  // back end settle before anything touches the registers.
  task automatic drain();
    in_ch.valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic coord_t near(coord_t c, int span);
    return c + coord_t'($signed($urandom_range(0, 2 * span)) - span);
  endfunction

  // One random polyhedron: mostly a center with nearby ligands, now and then
  // full-range atoms, an empty separator or an overfull shell.
  task automatic random_poly();
    coord_t cx, cy, cz;
    int     n, span;
    n = $urandom_range(0, 9);
    if (n == 9) n = $urandom_range(9, 11);
    span = ($urandom_range(0, 1) != 0) ? 1 << 17 : 1 << 20;
    cx = coord_t'($urandom);
    cy = coord_t'($urandom);
    cz = coord_t'($urandom);
    if ($urandom_range(0, 19) != 0) atom(cx, cy, cz);
    for (int k = 0; k < n; k++) begin
      if ($urandom_range(0, 4) == 0)
        atom(coord_t'($urandom), coord_t'($urandom), coord_t'($urandom));
      else if ($urandom_range(0, 29) == 0)
        atom(cx, cy, cz);
      else
        atom(near(cx, span), near(cy, span), near(cz, span));
    end
    separator();
  endtask

  task automatic random_phase(int words);
    int stop_at;
    stop_at = words_sent + words;
    while (words_sent < stop_at) random_poly();
    drain();
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: open cell, so every axis uses the plain difference.
    write_cells('0, '0, '0);
    write_reg(REG_UNUSED, 23'h7fffff);
    separator();                              // separator with no center
    atom('0, '0, '0);
    atom(24'sd65536, '0, '0);
    atom(-24'sd65536, '0, '0);                // opposite bond: 180 degrees
    atom('0, 24'sd65536, '0);                 // right angle
    atom('0, '0, '0);                         // zero-length bond
    atom(24'sh7fffff, 24'sh7fffff, 24'sh7fffff);
    atom(24'sh800000, 24'sh800000, 24'sh800000);
    atom(24'sd131072, '0, '0);                // same direction: 0 degrees
    separator();
    atom(24'sd100, 24'sd200, 24'sd300);       // center with no ligands
    separator();
    atom(24'sd100, 24'sd200, 24'sd300);       // overfull shell, flag on marker
    for (int k = 0; k < NEIGHBOR_CAP + 2; k++)
      atom(near(24'sd100, 1 << 16), near(24'sd200, 1 << 16), near(24'sd300, 1 << 16));
    separator();
    drain();

    // Largest cell, then small cells where images fold and cosines saturate, then random cells.
    write_cells(23'h7fffff, 23'h7fffff, 23'h7fffff);
    random_phase(RANDOM_WORDS / 3);
    write_cells(23'h10000, 23'h28000, 23'h1);
    random_phase(RANDOM_WORDS / 3);
    write_cells(cell_t'($urandom), cell_t'($urandom), cell_t'($urandom));
    random_phase(RANDOM_WORDS / 3);

    $display("covered %0d input words in %0d polyhedra, %0d result words checked",
             words_sent, polys_sent, sb.checked);
    $display("zero-length bonds %0d, overfull shells %0d, four cell settings",
             sb.degen_seen, sb.overflow_seen);
    if (sb.errors == 0 && sb.pending.size() == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end
endmodule

/* polyhedron_bond_angles.f */
+incdir+rtl
rtl/pba_pkg.sv
rtl/pba_chan_if.sv
rtl/pba_front.sv
rtl/pba_fifo.sv
rtl/pba_angle.sv
rtl/pba_back.sv
rtl/polyhedron_bond_angles.sv
dv/testbench.sv
